// ----- sv/lcdns_pkg.sv -----
`default_nettype none

package lcdns_pkg;

    localparam int MAX_BYTES = 10;
    localparam int IDX_W     = $clog2(MAX_BYTES);

    localparam logic [2:0] ACT_INIT    = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_CURSOR  = 3'd2;
    localparam logic [2:0] ACT_DISPLAY = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;
    localparam logic [2:0] ACT_GLYPH   = 3'd5;

    localparam logic [7:0] INIT_WAKE     = 8'h33;
    localparam logic [7:0] INIT_FOURBIT  = 8'h32;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISPLAY   = 8'h08;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DDRAM     = 8'h80;
    localparam logic [7:0] CMD_CGRAM     = 8'h40;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  char_code;
        logic [1:0]  row;
        logic [5:0]  column;
        logic        display_on;
        logic        cursor_on;
        logic        blink_on;
        logic [63:0] glyph_rows;
    } cmd_t;

    typedef struct packed {
        logic [3:0] nibble;
        logic       register_select;
        logic       last;
    } nib_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [MAX_BYTES-1:0]      rs;
        logic [IDX_W-1:0]          count;
    } run_t;

endpackage

`default_nettype wire

// ----- sv/lcdns_cmd.sv -----
`default_nettype none

module lcdns_cmd #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 take,
    input  lcdns_pkg::cmd_t     cmd,
    output logic                has_run,
    output lcdns_pkg::run_t     run
);
    import lcdns_pkg::*;

    localparam logic [3:0] COL_MAX = 4'(COLUMNS - 1);
    localparam logic [1:0] ROW_MAX = 2'(ROWS - 1);

    logic       row_reg, row_next;
    logic [3:0] col_reg, col_next;
    logic       disp_reg, disp_next;
    logic       curs_reg, curs_next;
    logic       blink_reg, blink_next;

    logic [4:0] col_inc;
    logic [1:0] row_inc;
    logic [7:0] pos_cur;

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        disp_next  = disp_reg;
        curs_next  = curs_reg;
        blink_next = blink_reg;
        has_run    = 1'b1;
        run        = '0;
        col_inc    = {1'b0, col_reg} + 5'd1;
        row_inc    = {1'b0, row_reg} + 2'd1;
        pos_cur    = CMD_DDRAM | {1'b0, row_reg, 2'b00, col_reg};

        case (cmd.action)
            ACT_INIT:
            begin
                run.bytes[0] = INIT_WAKE;
                run.bytes[1] = INIT_FOURBIT;
                run.bytes[2] = CMD_FUNC_SET;
                run.bytes[3] = CMD_DISPLAY | {6'b0, curs_reg, blink_reg};
                run.bytes[4] = CMD_CLEAR;
                run.bytes[5] = CMD_ENTRY;
                run.bytes[6] = CMD_DISPLAY | {5'b0, 1'b1, curs_reg, blink_reg};
                run.count    = IDX_W'(7);
                disp_next    = 1'b1;
                row_next     = 1'b0;
                col_next     = '0;
            end
            ACT_WRITE:
            begin
                run.bytes[0] = cmd.char_code;
                run.rs[0]    = RS_DATA;
                run.count    = IDX_W'(1);
                if (col_inc > {1'b0, COL_MAX})
                begin
                    col_next = '0;
                    row_next = (row_inc > ROW_MAX) ? 1'b0 : row_inc[0];
                    run.bytes[1] = CMD_DDRAM | {1'b0, row_next, 6'b0};
                    run.count    = IDX_W'(2);
                end
                else
                begin
                    col_next = col_inc[3:0];
                end
            end
            ACT_CURSOR:
            begin
                row_next = (cmd.row > ROW_MAX) ? ROW_MAX[0] : cmd.row[0];
                col_next = (cmd.column > {2'b00, COL_MAX}) ? COL_MAX : cmd.column[3:0];
                run.bytes[0] = CMD_DDRAM | {1'b0, row_next, 2'b00, col_next};
                run.count    = IDX_W'(1);
            end
            ACT_DISPLAY:
            begin
                disp_next  = cmd.display_on;
                curs_next  = cmd.cursor_on;
                blink_next = cmd.blink_on;
                run.bytes[0] = CMD_DISPLAY
                    | {5'b0, cmd.display_on, cmd.cursor_on, cmd.blink_on};
                run.count    = IDX_W'(1);
            end
            ACT_CLEAR:
            begin
                run.bytes[0] = CMD_CLEAR;
                run.count    = IDX_W'(1);
                row_next     = 1'b0;
                col_next     = '0;
            end
            ACT_GLYPH:
            begin
                run.bytes[0] = CMD_CGRAM | {2'b00, cmd.char_code[2:0], 3'b000};
                for (int i = 0; i < 8; i++)
                begin
                    run.bytes[i+1] = cmd.glyph_rows[8*i +: 8];
                    run.rs[i+1]    = RS_DATA;
                end
                run.bytes[9] = pos_cur;
                run.count    = IDX_W'(10);
            end
            default:
            begin
                has_run = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= 1'b0;
            col_reg   <= '0;
            disp_reg  <= 1'b0;
            curs_reg  <= 1'b0;
            blink_reg <= 1'b0;
        end
        else if (take)
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            disp_reg  <= disp_next;
            curs_reg  <= curs_next;
            blink_reg <= blink_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/char_lcd_nibble_sequencer.sv -----
`default_nettype none
// An accepted command is registered as a run, and its first nibble then in the output register.
// Throughput: one nibble per cycle while nib_stall is low; a command holds the sequencer
// until all its nibbles are out (2 to 20, init 14, glyph 20); unused actions send none.
// The next command is accepted in the cycle that the last nibble of a run moves out.
// Reset clears the cursor position, the display flags and all valid bits.

module char_lcd_nibble_sequencer #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_stall,
    input  lcdns_pkg::cmd_t     cmd,
    output logic                nib_valid,
    input  wire                 nib_stall,
    output lcdns_pkg::nib_t     nib
);
    import lcdns_pkg::*;

    run_t             run_reg;
    logic             run_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             half_reg;
    nib_t             out_reg;
    logic             out_valid_reg;

    run_t             new_run;
    logic             has_run;
    logic             accept;
    logic             advance;
    logic             final_nib;
    logic [7:0]       cur_byte;

    lcdns_cmd #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cmd (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (accept),
        .cmd     (cmd),
        .has_run (has_run),
        .run     (new_run)
    );

    assign advance   = run_valid_reg && (!out_valid_reg || !nib_stall);
    assign final_nib = half_reg && (idx_reg == run_reg.count - IDX_W'(1));
    assign cmd_stall = run_valid_reg && !(advance && final_nib);
    assign accept    = cmd_valid && !cmd_stall;
    assign cur_byte  = run_reg.bytes[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            half_reg      <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!nib_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept && has_run)
            begin
                run_valid_reg <= 1'b1;
                idx_reg       <= '0;
                half_reg      <= 1'b0;
            end
            else if (advance)
            begin
                if (final_nib)
                begin
                    run_valid_reg <= 1'b0;
                end
                half_reg <= !half_reg;
                if (half_reg)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_run)
        begin
            run_reg <= new_run;
        end
        if (advance)
        begin
            out_reg.nibble          <= half_reg ? cur_byte[3:0] : cur_byte[7:4];
            out_reg.register_select <= run_reg.rs[idx_reg];
            out_reg.last            <= final_nib;
        end
    end

    assign nib_valid = out_valid_reg;
    assign nib       = out_reg;

endmodule

`default_nettype wire
